>>> sv/css_pkg.sv
// css_pkg: shared constants, types and helpers for the coordinated servo stepper
// used by css_lane, css_merge, coordinated_servo_stepper and css_checker
// no dependencies
package css_pkg;

  localparam int SERVO_COUNT = 6;
  localparam int POS_W       = 8;
  localparam int DIFF_W      = POS_W + 1;
  localparam int QUO_W       = 15;                  // holds 255 * 100
  localparam int PCT_W       = 7;
  localparam int IDX_W       = 3;
  localparam int CNT_W       = $clog2(QUO_W + 1);
  localparam int TICK_W      = 8;

  typedef logic [POS_W-1:0]         pos_t;
  typedef logic signed [DIFF_W-1:0] diff_t;
  typedef logic [QUO_W-1:0]         quo_t;
  typedef logic [PCT_W-1:0]         pct_t;
  typedef logic [IDX_W-1:0]         idx_t;
  typedef logic [CNT_W-1:0]         cnt_t;
  typedef logic [TICK_W-1:0]        tick_t;
  typedef logic [SERVO_COUNT-1:0]   mask_t;

  localparam pos_t PCT_SCALE = 8'd100;

  // per-lane commands from the sequencer
  typedef struct packed {
    logic start_load;
    pos_t target;
    logic cfg_load;
    pos_t cfg_value;
    logic div_load;
    logic div_run;
    logic step;
  } lane_ctrl_t;

  // per-lane status toward the merge stage
  typedef struct packed {
    pos_t  cur;
    diff_t diff;
    diff_t new_diff;
    quo_t  pct;
    logic  can_step;
  } lane_stat_t;

  function automatic pos_t mag(diff_t v);
    diff_t n;
    n = (v < 0) ? -v : v;
    return n[POS_W-1:0];
  endfunction

  function automatic pos_t init_pos(int unsigned i);
    pos_t p;
    case (i)
      0:       p = 8'd128;
      1:       p = 8'd85;
      2:       p = 8'd221;
      3:       p = 8'd39;
      4:       p = 8'd122;
      5:       p = 8'd127;
      default: p = 8'd128;
    endcase
    return p;
  endfunction

endpackage

>>> sv/css_lane.sv
// css_lane: one servo lane - position, start, destination and difference registers
// plus a restoring divider for moved*100/|diff|, one quotient bit per cycle
// depends on css_pkg
module css_lane (
  input  logic                clk,
  input  logic                rst,
  input  css_pkg::pos_t       rst_pos,
  input  css_pkg::lane_ctrl_t ctrl,
  output css_pkg::lane_stat_t stat
);

  css_pkg::pos_t  cur;
  css_pkg::pos_t  start;
  css_pkg::pos_t  dest;
  css_pkg::diff_t diff;
  css_pkg::pos_t  rem;
  css_pkg::quo_t  dq;

  css_pkg::diff_t new_diff;
  css_pkg::pos_t  moved;
  css_pkg::quo_t  dividend;
  css_pkg::pos_t  den;
  logic [css_pkg::POS_W:0] r;
  logic [css_pkg::POS_W:0] sub;
  logic           ge;
  css_pkg::pos_t  rem_next;
  css_pkg::pos_t  nxt;

  always_comb begin
    new_diff = (ctrl.target != '0)
             ? css_pkg::diff_t'({1'b0, ctrl.target}) - css_pkg::diff_t'({1'b0, cur})
             : '0;
    moved    = css_pkg::mag(css_pkg::diff_t'({1'b0, start}) - css_pkg::diff_t'({1'b0, cur}));
    dividend = css_pkg::quo_t'(moved) * css_pkg::quo_t'(css_pkg::PCT_SCALE);
    den      = css_pkg::mag(diff);
    r        = {rem, dq[css_pkg::QUO_W-1]};
    sub      = r - {1'b0, den};
    ge       = (r >= {1'b0, den});
    rem_next = ge ? sub[css_pkg::POS_W-1:0] : r[css_pkg::POS_W-1:0];
    nxt      = (dest < cur) ? cur - 1'b1 : cur + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur   <= rst_pos;
      start <= '0;
      dest  <= '0;
      diff  <= '0;
    end else if (ctrl.start_load) begin
      start <= cur;
      dest  <= ctrl.target;
      diff  <= new_diff;
    end else if (ctrl.step) begin
      cur <= nxt;
    end else if (ctrl.cfg_load) begin
      cur <= ctrl.cfg_value;
    end
  end

  // divider datapath, no reset needed
  always_ff @(posedge clk) begin
    if (ctrl.div_load) begin
      rem <= '0;
      dq  <= dividend;
    end else if (ctrl.div_run) begin
      rem <= rem_next;
      dq  <= {dq[css_pkg::QUO_W-2:0], ge};
    end
  end

  assign stat.cur      = cur;
  assign stat.diff     = diff;
  assign stat.new_diff = new_diff;
  assign stat.pct      = dq;
  assign stat.can_step = (cur != dest) && (nxt != '0);

endmodule

>>> sv/css_merge.sv
// css_merge: combines lane results - leader pick on a start item and
// in-order step decisions with the running percent on a tick
// depends on css_pkg
module css_merge (
  input  css_pkg::lane_stat_t stat [css_pkg::SERVO_COUNT],
  input  css_pkg::diff_t      leader,
  input  css_pkg::pct_t       percent,
  output css_pkg::mask_t      step,
  output css_pkg::pct_t       percent_next,
  output css_pkg::diff_t      lead_next,
  output css_pkg::pos_t       best
);

  always_comb begin
    css_pkg::pct_t pd;
    css_pkg::pos_t bst;
    css_pkg::diff_t ld;
    pd   = percent;
    step = '0;
    for (int i = 0; i < css_pkg::SERVO_COUNT; i++) begin
      if (stat[i].diff != '0) begin
        if (stat[i].diff == leader) begin
          step[i] = stat[i].can_step;
          pd      = stat[i].pct[css_pkg::PCT_W-1:0];
        end else if (stat[i].pct < css_pkg::quo_t'(pd)) begin
          step[i] = stat[i].can_step;
        end
      end
    end
    percent_next = pd;

    // first lane with the largest magnitude wins
    bst = '0;
    ld  = '0;
    for (int i = 0; i < css_pkg::SERVO_COUNT; i++) begin
      if (stat[i].new_diff != '0 && css_pkg::mag(stat[i].new_diff) > bst) begin
        bst = css_pkg::mag(stat[i].new_diff);
        ld  = stat[i].new_diff;
      end
    end
    best      = bst;
    lead_next = ld;
  end

endmodule

>>> sv/coordinated_servo_stepper.sv
// coordinated_servo_stepper: top level - sequencer, lanes, merge and output register
// depends on css_pkg, css_lane, css_merge
//
// channel   direction  handshake            payload
// in        to block   in_valid/in_ready    cmd, six targets
// out       from block out_valid/out_ready  six positions, stepped_mask, busy_res
// cfg       to block   cfg_we (no wait)     cfg_index, cfg_data
//
// a start item goes from accept straight to emit; a tick item during a move runs accept,
// the divider in every lane at once, the merge/apply state and emit; an idle tick skips to emit
// the divider width (one quotient bit per cycle, 15 bits) sets the length of the divider run
// one item is in work at a time; a new item is accepted while a result waits
// reset is synchronous and puts every servo at its default start position
// a stalled output holds the finished item until out_ready; the next one waits in emit
module coordinated_servo_stepper (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 cmd,
  input  css_pkg::pos_t        rotate_target,
  input  css_pkg::pos_t        shoulder_target,
  input  css_pkg::pos_t        elbow_target,
  input  css_pkg::pos_t        wrist_target,
  input  css_pkg::pos_t        grip_rotate_target,
  input  css_pkg::pos_t        grip_target,
  output logic                 out_valid,
  input  logic                 out_ready,
  output css_pkg::pos_t        rotate_pos,
  output css_pkg::pos_t        shoulder_pos,
  output css_pkg::pos_t        elbow_pos,
  output css_pkg::pos_t        wrist_pos,
  output css_pkg::pos_t        grip_rotate_pos,
  output css_pkg::pos_t        grip_pos,
  output css_pkg::mask_t       stepped_mask,
  output logic                 busy_res,
  input  logic                 cfg_we,
  input  css_pkg::idx_t        cfg_index,
  input  css_pkg::pos_t        cfg_data
);

  // one-hot sequencer states
  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_DIV   = 4'b0010,
    S_APPLY = 4'b0100,
    S_EMIT  = 4'b1000
  } state_t;

  state_t              state;
  css_pkg::tick_t      ticks_left;
  css_pkg::pct_t       percent;
  css_pkg::diff_t      leader;
  css_pkg::cnt_t       cnt;
  css_pkg::mask_t      mask;

  css_pkg::pos_t       tgt  [css_pkg::SERVO_COUNT];
  css_pkg::lane_ctrl_t ctrl [css_pkg::SERVO_COUNT];
  css_pkg::lane_stat_t stat [css_pkg::SERVO_COUNT];

  css_pkg::mask_t      step_vec;
  css_pkg::pct_t       percent_next;
  css_pkg::diff_t      lead_next;
  css_pkg::pos_t       best;

  logic accept;
  logic emit_go;
  logic ticking;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign ticking  = (ticks_left != '0);
  // output slot is free or being emptied this cycle
  assign emit_go  = (state == S_EMIT) && (!out_valid || out_ready);

  // target ports in servo order
  assign tgt[0] = rotate_target;
  assign tgt[1] = shoulder_target;
  assign tgt[2] = elbow_target;
  assign tgt[3] = wrist_target;
  assign tgt[4] = grip_rotate_target;
  assign tgt[5] = grip_target;

  // lane commands
  always_comb begin
    for (int i = 0; i < css_pkg::SERVO_COUNT; i++) begin
      ctrl[i].start_load = accept && cmd;
      ctrl[i].target     = tgt[i];
      // config loads the position only when no move runs
      ctrl[i].cfg_load   = cfg_we && (cfg_index == css_pkg::idx_t'(i)) && !ticking;
      ctrl[i].cfg_value  = cfg_data;
      ctrl[i].div_load   = accept && !cmd && ticking;
      ctrl[i].div_run    = (state == S_DIV);
      ctrl[i].step       = (state == S_APPLY) && step_vec[i];
    end
  end

  for (genvar g = 0; g < css_pkg::SERVO_COUNT; g++) begin : g_lane
    css_lane u_lane (
      .clk     (clk),
      .rst     (rst),
      .rst_pos (css_pkg::init_pos(g)),
      .ctrl    (ctrl[g]),
      .stat    (stat[g])
    );
  end

  css_merge u_merge (
    .stat         (stat),
    .leader       (leader),
    .percent      (percent),
    .step         (step_vec),
    .percent_next (percent_next),
    .lead_next    (lead_next),
    .best         (best)
  );

  // sequencer and move state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      ticks_left <= '0;
      percent    <= '0;
      leader     <= '0;
      cnt        <= '0;
      mask       <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (cmd) begin
              // start item: record leader, no servo moves, result busy shows whether the new count is nonzero
              leader     <= lead_next;
              ticks_left <= css_pkg::tick_t'(best);
              percent    <= '0;
              mask       <= '0;
              state      <= S_EMIT;
            end else if (ticking) begin
              cnt   <= css_pkg::cnt_t'(css_pkg::QUO_W);
              state <= S_DIV;
            end else begin
              // tick while idle
              mask  <= '0;
              state <= S_EMIT;
            end
          end
        end
        S_DIV: begin
          cnt <= cnt - 1'b1;
          if (cnt == css_pkg::cnt_t'(1)) begin
            state <= S_APPLY;
          end
        end
        S_APPLY: begin
          percent    <= percent_next;
          mask       <= step_vec;
          ticks_left <= ticks_left - 1'b1;
          state      <= S_EMIT;
        end
        S_EMIT: begin
          if (emit_go) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_go) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      rotate_pos      <= stat[0].cur;
      shoulder_pos    <= stat[1].cur;
      elbow_pos       <= stat[2].cur;
      wrist_pos       <= stat[3].cur;
      grip_rotate_pos <= stat[4].cur;
      grip_pos        <= stat[5].cur;
      stepped_mask    <= mask;
      busy_res        <= ticking;
    end
  end

endmodule

>>> sv/css_checker.sv
// css_checker: port-level assertions for coordinated_servo_stepper, with bind
// depends on css_pkg and the top level's ports
module css_checker (
  input logic           clk,
  input logic           rst,
  input logic           in_valid,
  input logic           in_ready,
  input logic           out_valid,
  input logic           out_ready,
  input css_pkg::pos_t  rotate_pos,
  input css_pkg::pos_t  grip_pos,
  input css_pkg::mask_t stepped_mask,
  input logic           busy_res
);

  // a held result stays valid
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // a held result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(rotate_pos) && $stable(grip_pos)
      && $stable(stepped_mask) && $stable(busy_res))
    else $error("result payload changed while stalled");

  // one item in work at a time
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second item accepted while busy");

  // a result appears only after the work of an item, never straight from idle
  a_emit_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result emitted without a finished item");

endmodule

bind coordinated_servo_stepper css_checker u_css_checker (.*);

>>> verif/servo_step_checker.sv
`timescale 1ns / 100ps
// servo_step_checker: predicts each result item of the coordinated servo stepper and compares
// depends on css_pkg; watches the in, out and cfg ports beside the block in the test top
module servo_step_checker (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic           in_ready,
  input  logic           cmd,
  input  css_pkg::pos_t  rotate_target,
  input  css_pkg::pos_t  shoulder_target,
  input  css_pkg::pos_t  elbow_target,
  input  css_pkg::pos_t  wrist_target,
  input  css_pkg::pos_t  grip_rotate_target,
  input  css_pkg::pos_t  grip_target,
  input  logic           out_valid,
  input  logic           out_ready,
  input  css_pkg::pos_t  rotate_pos,
  input  css_pkg::pos_t  shoulder_pos,
  input  css_pkg::pos_t  elbow_pos,
  input  css_pkg::pos_t  wrist_pos,
  input  css_pkg::pos_t  grip_rotate_pos,
  input  css_pkg::pos_t  grip_pos,
  input  css_pkg::mask_t stepped_mask,
  input  logic           busy_res,
  input  logic           cfg_we,
  input  css_pkg::idx_t  cfg_index,
  input  css_pkg::pos_t  cfg_data,
  output int             outstanding,
  output int             fail_count,
  output int             results_checked
);

  typedef css_pkg::pos_t [css_pkg::SERVO_COUNT-1:0] pose_t;

  typedef struct packed {
    pose_t          pos;
    css_pkg::mask_t mask;
    logic           busy;
  } servo_result_t;

  // positions after reset, servo 0 in the low byte
  localparam pose_t HOME_POSE = {8'd127, 8'd122, 8'd39, 8'd221, 8'd85, 8'd128};

  pose_t          cur_pos;
  pose_t          start_pos;
  pose_t          dest_pos;
  css_pkg::diff_t travel [css_pkg::SERVO_COUNT];
  css_pkg::diff_t lead_travel;
  css_pkg::tick_t ticks_left;
  css_pkg::pct_t  lead_pct;
  servo_result_t  expected_poses [$];
  servo_result_t  want;
  pose_t          seen;
  int             errors  = 0;
  int             checked = 0;

  assign seen            = {grip_pos, grip_rotate_pos, wrist_pos, elbow_pos, shoulder_pos,
                            rotate_pos};
  assign fail_count      = errors;
  assign results_checked = checked;

  function automatic int magnitude(int v);
    return (v < 0) ? -v : v;
  endfunction

  // one item applied to the local copy of the servo state
  function automatic servo_result_t advance_servos(logic start, pose_t goal);
    servo_result_t r;
    int            best;
    int            moved;
    int            pct;
    css_pkg::pos_t nxt;
    logic          go;
    r.mask = '0;
    if (start) begin
      best        = 0;
      lead_travel = '0;
      for (int i = 0; i < css_pkg::SERVO_COUNT; i++) begin
        start_pos[i] = cur_pos[i];
        dest_pos[i]  = goal[i];
        travel[i]    = (goal[i] != 0)
                     ? css_pkg::diff_t'(int'(goal[i]) - int'(cur_pos[i])) : '0;
        if (travel[i] != 0 && magnitude(int'(travel[i])) > best) begin
          best        = magnitude(int'(travel[i]));
          lead_travel = travel[i];
        end
      end
      ticks_left = css_pkg::tick_t'(best);
      lead_pct   = '0;
    end else if (ticks_left != 0) begin
      for (int i = 0; i < css_pkg::SERVO_COUNT; i++) begin
        if (travel[i] != 0) begin
          moved = magnitude(int'(start_pos[i]) - int'(cur_pos[i])) & 255;
          pct   = moved * 100 / magnitude(int'(travel[i]));
          go    = (travel[i] == lead_travel) || (pct < int'(lead_pct));
          if (travel[i] == lead_travel)
            lead_pct = css_pkg::pct_t'(pct);
          if (go && cur_pos[i] != dest_pos[i]) begin
            nxt = (dest_pos[i] < cur_pos[i]) ? cur_pos[i] - 8'd1 : cur_pos[i] + 8'd1;
            if (nxt != 0) begin
              cur_pos[i] = nxt;
              r.mask[i]  = 1'b1;
            end
          end
        end
      end
      ticks_left = ticks_left - 1'b1;
    end
    r.pos  = cur_pos;
    r.busy = (ticks_left != 0);
    return r;
  endfunction

  function automatic void compare_field(string field, int exp_val, int act_val);
    if (exp_val != act_val) begin
      if (errors < 10)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, exp_val, act_val);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      cur_pos     = HOME_POSE;
      start_pos   = '0;
      dest_pos    = '0;
      lead_travel = '0;
      ticks_left  = '0;
      lead_pct    = '0;
      for (int i = 0; i < css_pkg::SERVO_COUNT; i++)
        travel[i] = '0;
      expected_poses.delete();
      outstanding <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_poses.size() == 0) begin
          if (errors < 10)
            $display("%0t: result item with no expectation waiting", $time);
          errors++;
        end else begin
          want = expected_poses.pop_front();
          for (int i = 0; i < css_pkg::SERVO_COUNT; i++)
            compare_field($sformatf("position %0d", i), int'(want.pos[i]), int'(seen[i]));
          compare_field("stepped_mask", int'(want.mask), int'(stepped_mask));
          compare_field("busy_res", int'(want.busy), int'(busy_res));
          checked++;
        end
      end
      // writes beyond the servo list are dropped
      if (cfg_we && cfg_index < css_pkg::SERVO_COUNT) begin
        if (ticks_left == 0)
          cur_pos[cfg_index] = cfg_data;
      end
      if (in_valid && in_ready)
        expected_poses.push_back(advance_servos(cmd, {grip_target, grip_rotate_target,
                                                      wrist_target, elbow_target,
                                                      shoulder_target, rotate_target}));
      outstanding <= expected_poses.size();
    end
  end

endmodule

>>> verif/coordinated_servo_stepper_test.sv
`timescale 1ns / 100ps
// coordinated_servo_stepper_test: stimulus, register settings and verdict for the servo stepper
// depends on css_pkg, the coordinated_servo_stepper rtl and servo_step_checker
module coordinated_servo_stepper_test;

  typedef css_pkg::pos_t [css_pkg::SERVO_COUNT-1:0] pose_t;

  localparam logic OP_TICK      = 1'b0;
  localparam logic OP_START     = 1'b1;
  localparam int   CYCLE_LIMIT  = 500000;
  localparam int   RANDOM_ITEMS = 650;
  localparam int   PHASES       = 5;
  localparam int   IDLE_PERCENT = 9;
  localparam int   DRAIN_CYCLES = 40;
  localparam int   LONG_MOVE    = 256;  // more ticks than the longest move can take
  // random items per register phase; the full-length move and the overrun
  // of each phase's last scenario come out of the total
  localparam int   PHASE_ITEMS  = (RANDOM_ITEMS - LONG_MOVE) / PHASES - 16;

  logic           clk                = 1'b0;
  logic           rst                = 1'b1;
  logic           in_valid           = 1'b0;
  logic           in_ready;
  logic           cmd                = OP_TICK;
  css_pkg::pos_t  rotate_target      = '0;
  css_pkg::pos_t  shoulder_target    = '0;
  css_pkg::pos_t  elbow_target       = '0;
  css_pkg::pos_t  wrist_target       = '0;
  css_pkg::pos_t  grip_rotate_target = '0;
  css_pkg::pos_t  grip_target        = '0;
  logic           out_valid;
  logic           out_ready          = 1'b0;
  css_pkg::pos_t  rotate_pos;
  css_pkg::pos_t  shoulder_pos;
  css_pkg::pos_t  elbow_pos;
  css_pkg::pos_t  wrist_pos;
  css_pkg::pos_t  grip_rotate_pos;
  css_pkg::pos_t  grip_pos;
  css_pkg::mask_t stepped_mask;
  logic           busy_res;
  logic           cfg_we             = 1'b0;
  css_pkg::idx_t  cfg_index          = '0;
  css_pkg::pos_t  cfg_data           = '0;

  int    outstanding;
  int    fail_count;
  int    results_checked;

  // stimulus bookkeeping
  pose_t last_pos    = '0;    // positions from the newest result item
  logic  last_busy   = 1'b0;
  bit    quiet       = 1'b0;  // no idling on either side while set
  int    items_sent  = 0;
  int    starts_sent = 0;
  int    ticks_sent  = 0;
  int    reg_writes  = 0;
  int    cycle_count = 0;

  coordinated_servo_stepper dut (.*);

  servo_step_checker step_check (.*);

  initial begin
    forever #4 clk = ~clk;
  end

  // receiver: random stalls, and a record of where the servos stand
  always @(posedge clk) begin
    if (rst)
      out_ready <= 1'b0;
    else
      out_ready <= quiet || ($urandom_range(0, 99) >= IDLE_PERCENT);
    if (out_valid && out_ready) begin
      last_pos  <= {grip_pos, grip_rotate_pos, wrist_pos, elbow_pos, shoulder_pos, rotate_pos};
      last_busy <= busy_res;
    end
  end

  // watchdog on the whole run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // targets with a bias toward zero (servo left alone) and the ends of the range
  function automatic pose_t random_pose();
    pose_t p;
    for (int i = 0; i < css_pkg::SERVO_COUNT; i++) begin
      case ($urandom_range(0, 7))
        0:       p[i] = 8'd0;
        1:       p[i] = 8'd1;
        2:       p[i] = 8'd255;
        default: p[i] = css_pkg::pos_t'($urandom_range(0, 255));
      endcase
    end
    return p;
  endfunction

  // one item on the in channel, with a random gap ahead of it
  task automatic send_item(input logic op, input pose_t goal);
    while (!quiet && $urandom_range(0, 99) < IDLE_PERCENT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid           <= 1'b1;
    cmd                <= op;
    rotate_target      <= goal[0];
    shoulder_target    <= goal[1];
    elbow_target       <= goal[2];
    wrist_target       <= goal[3];
    grip_rotate_target <= goal[4];
    grip_target        <= goal[5];
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    if (op == OP_START)
      starts_sent++;
    else
      ticks_sent++;
  endtask

  // start item followed by a run of ticks; targets on tick items are ignored
  task automatic launch_move(input pose_t goal, input int ticks);
    send_item(OP_START, goal);
    repeat (ticks) send_item(OP_TICK, random_pose());
  endtask

  // hold off the sender until every result item has come back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // move from the present positions by up to span units, run to the end plus a few idle ticks
  // with tie set every servo aims exactly span away, each with a random sign, clamped to 1..255
  task automatic small_move(input int span, input bit tie);
    pose_t goal;
    int    aim;
    int    travel_len;
    int    need;
    drain();
    need = 0;
    for (int i = 0; i < css_pkg::SERVO_COUNT; i++) begin
      if (tie)
        aim = int'(last_pos[i]) + ($urandom_range(0, 1) ? span : -span);
      else
        aim = int'(last_pos[i]) + int'($urandom_range(0, 2 * span)) - span;
      if (aim < 1)
        aim = 1;
      if (aim > 255)
        aim = 255;
      if (!tie && $urandom_range(0, 9) == 0)
        aim = 0;
      goal[i] = aim[7:0];
      travel_len = aim - int'(last_pos[i]);
      if (travel_len < 0)
        travel_len = -travel_len;
      if (aim != 0 && travel_len > need)
        need = travel_len;
    end
    launch_move(goal, need + $urandom_range(0, 3));
  endtask

  // all six registers, then the two indexes past the list
  task automatic write_settings(input pose_t vals);
    for (int i = 0; i < css_pkg::SERVO_COUNT + 2; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= css_pkg::idx_t'(i);
      if (i < css_pkg::SERVO_COUNT)
        cfg_data <= vals[i];
      else
        cfg_data <= css_pkg::pos_t'($urandom_range(0, 255));
      @(posedge clk);
      reg_writes++;
    end
    cfg_we <= 1'b0;
  endtask

  initial begin
    pose_t vals;
    int    done;
    int    sent_mark;
    int    pick;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed part, reset positions
    // tick while idle, all-ones targets must be ignored
    send_item(OP_TICK, '1);
    // every target zero: no move, then another idle tick
    launch_move('0, 1);
    // targets equal to present positions
    small_move(0, 1'b0);
    // same travel on all servos with mixed signs: leader tie and followers
    small_move(6, 1'b1);
    // range extremes, the second start aborts the first mid-move
    launch_move({8'd1, 8'd255, 8'd1, 8'd255, 8'd1, 8'd255}, 3);
    launch_move({8'd255, 8'd1, 8'd255, 8'd1, 8'd255, 8'd1}, 2);

    // register phases; phase 0 writes while a move is still open,
    // odd phases abort an open move with an all-zero start so the writes also load positions
    for (int p = 0; p < PHASES; p++) begin
      drain();
      if (p % 2 == 1 && last_busy) begin
        send_item(OP_START, '0);
        drain();
      end
      for (int i = 0; i < css_pkg::SERVO_COUNT; i++) begin
        case (p)
          1:       vals[i] = 8'd1;
          2:       vals[i] = 8'd255;
          3:       vals[i] = (i % 2 == 0) ? 8'd1 : 8'd255;
          default: vals[i] = css_pkg::pos_t'($urandom_range(1, 255));
        endcase
      end
      write_settings(vals);
      // phase 2 runs without any idling on either side
      quiet <= (p == 2);
      // one full-length move in the first phase
      if (p == 0)
        launch_move(random_pose(), LONG_MOVE);
      done = 0;
      while (done < PHASE_ITEMS) begin
        sent_mark = items_sent;
        pick      = $urandom_range(0, 99);
        if (pick < 45)
          small_move($urandom_range(1, 24), 1'b0);
        else if (pick < 55)
          small_move($urandom_range(1, 12), 1'b1);
        else if (pick < 80)
          launch_move(random_pose(), $urandom_range(1, 30));
        else
          // noise: loose starts and ticks in any order
          repeat ($urandom_range(1, 6))
            send_item(($urandom_range(0, 3) == 0) ? OP_START : OP_TICK, random_pose());
        done += items_sent - sent_mark;
      end
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d start and %0d tick items across %0d register settings",
             starts_sent, ticks_sent, PHASES + 1);
    $display("%0d register writes, %0d result items compared", reg_writes, results_checked);
    if (fail_count == 0 && outstanding == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

>>> filelist.f
sv/css_pkg.sv
sv/css_lane.sv
sv/css_merge.sv
sv/coordinated_servo_stepper.sv
sv/css_checker.sv
verif/servo_step_checker.sv
verif/coordinated_servo_stepper_test.sv
